// ===== rtl/core/spi_pwm_encoder_command_slave_top_macros.svh =====
// assertion helpers for the spi pwm encoder command slave
// all checks are clocked on aclk and held off while aresetn is low
`ifndef SPI_PWM_ENCODER_COMMAND_SLAVE_TOP_MACROS_SVH
`define SPI_PWM_ENCODER_COMMAND_SLAVE_TOP_MACROS_SVH

// same-cycle implication
`define SPWMCS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPWMCS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/spwmcs_pkg.sv =====
// ----------------------------------------------------------------------------
// spwmcs_pkg
// Types, command codes and byte helpers shared by the SPI PWM/encoder slave.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spwmcs_pkg;

    // command codes
    localparam logic [7:0] CMD_WR_PITCH = 8'h10;
    localparam logic [7:0] CMD_WR_YAW   = 8'h11;
    localparam logic [7:0] CMD_WR_ALL   = 8'h12;
    localparam logic [7:0] CMD_RD_PITCH = 8'h20;
    localparam logic [7:0] CMD_RD_YAW   = 8'h21;
    localparam logic [7:0] CMD_RD_ALL   = 8'h22;
    localparam logic [7:0] CMD_STATUS   = 8'h30;

    // byte position in a frame, saturating
    localparam int unsigned IDX_W = 4;
    localparam logic [IDX_W-1:0] IDX_MAX = 4'hF;

    // stream widths
    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned M_TDATA_W = 40;

    // one pwm channel register
    typedef struct packed {
        logic        enable;
        logic        dir;
        logic [11:0] duty;
    } pwm_reg_t;

    // one received byte with the encoder counts beside it
    typedef struct packed {
        logic               frame_start;
        logic [7:0]         mosi_byte;
        logic signed [31:0] pitch_position;
        logic signed [31:0] yaw_position;
    } item_t;

    // one reply
    typedef struct packed {
        logic [7:0] miso_byte;
        pwm_reg_t   pitch;
        pwm_reg_t   yaw;
        logic       regs_updated;
    } result_t;

    // duty low byte plus flags byte -> register
    function automatic pwm_reg_t pack_reg(input logic [7:0] lo, input logic [7:0] flags);
        pwm_reg_t r;
        r.enable = flags[7];
        r.dir    = flags[6];
        r.duty   = {flags[5:2], lo};
        return r;
    endfunction

    // register -> flags byte, low two bits zero
    function automatic logic [7:0] flags_of(input pwm_reg_t r);
        return {r.enable, r.dir, r.duty[11:8], 2'b00};
    endfunction

    // big-endian byte k of a 32-bit word
    function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = v[31:24];
            2'd1:    b = v[23:16];
            2'd2:    b = v[15:8];
            default: b = v[7:0];
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/spwmcs_in_stage.sv =====
// ----------------------------------------------------------------------------
// spwmcs_in_stage
// Input register: holds one received byte until the command core takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spwmcs_in_stage
    import spwmcs_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    input  wire logic  take,
    output logic       held_valid,
    output item_t      held_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    // free when empty or when the held byte leaves this cycle
    assign in_ready = !valid_reg || take;
    assign load     = in_valid && in_ready;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    // control flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/spwmcs_core.sv =====
// ----------------------------------------------------------------------------
// spwmcs_core
// Command decode, frame state and pwm registers; one byte per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spwmcs_core
    import spwmcs_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  step,
    input  wire item_t item,
    output result_t    result
);

    logic [IDX_W-1:0] byte_idx_reg;
    logic [IDX_W-1:0] byte_idx_next;
    logic [7:0]       active_cmd_reg;
    logic [7:0]       active_cmd_next;
    logic [7:0]       staged_low_reg;
    logic [7:0]       staged_low_next;
    pwm_reg_t         staged_pitch_reg;
    pwm_reg_t         staged_pitch_next;
    logic [31:0]      pitch_snap_reg;
    logic [31:0]      pitch_snap_next;
    logic [31:0]      yaw_snap_reg;
    logic [31:0]      yaw_snap_next;
    pwm_reg_t         pitch_pwm_reg;
    pwm_reg_t         pitch_pwm_next;
    pwm_reg_t         yaw_pwm_reg;
    pwm_reg_t         yaw_pwm_next;

    logic             start;
    logic [7:0]       b;
    logic [7:0]       cmd;
    logic [IDX_W-1:0] pos;
    logic             is_read;
    logic [7:0]       miso;
    logic             updated;

    // byte decode and next state
    always_comb begin
        start   = item.frame_start;
        b       = item.mosi_byte;
        cmd     = start ? b : active_cmd_reg;
        pos     = start ? '0 : byte_idx_reg;
        is_read = (b == CMD_RD_PITCH) || (b == CMD_RD_YAW) || (b == CMD_RD_ALL);

        active_cmd_next   = cmd;
        staged_low_next   = staged_low_reg;
        staged_pitch_next = staged_pitch_reg;
        pitch_pwm_next    = pitch_pwm_reg;
        yaw_pwm_next      = yaw_pwm_reg;
        miso              = 8'h00;
        updated           = 1'b0;

        // snapshot on a read command byte, used at once for its first reply
        if (start && is_read) begin
            pitch_snap_next = $unsigned(item.pitch_position);
            yaw_snap_next   = $unsigned(item.yaw_position);
        end else begin
            pitch_snap_next = pitch_snap_reg;
            yaw_snap_next   = yaw_snap_reg;
        end

        // frame position, saturating
        if (start) begin
            byte_idx_next = {{(IDX_W-1){1'b0}}, 1'b1};
        end else if (byte_idx_reg != IDX_MAX) begin
            byte_idx_next = byte_idx_reg + {{(IDX_W-1){1'b0}}, 1'b1};
        end else begin
            byte_idx_next = byte_idx_reg;
        end

        unique case (cmd) inside
            CMD_WR_PITCH, CMD_WR_YAW: begin
                if (pos == 4'd1) begin
                    staged_low_next = b;
                end else if (pos == 4'd2) begin
                    if (cmd == CMD_WR_PITCH) begin
                        pitch_pwm_next = pack_reg(staged_low_reg, b);
                    end else begin
                        yaw_pwm_next = pack_reg(staged_low_reg, b);
                    end
                    updated = 1'b1;
                end
            end
            CMD_WR_ALL: begin
                if (pos == 4'd1 || pos == 4'd3) begin
                    staged_low_next = b;
                end else if (pos == 4'd2) begin
                    staged_pitch_next = pack_reg(staged_low_reg, b);
                end else if (pos == 4'd4) begin
                    pitch_pwm_next = staged_pitch_reg;
                    yaw_pwm_next   = pack_reg(staged_low_reg, b);
                    updated        = 1'b1;
                end
            end
            CMD_RD_PITCH: begin
                if (pos <= 4'd3) begin
                    miso = be_byte(pitch_snap_next, pos[1:0]);
                end
            end
            CMD_RD_YAW: begin
                if (pos <= 4'd3) begin
                    miso = be_byte(yaw_snap_next, pos[1:0]);
                end
            end
            CMD_RD_ALL: begin
                if (pos <= 4'd3) begin
                    miso = be_byte(pitch_snap_next, pos[1:0]);
                end else if (pos <= 4'd7) begin
                    miso = be_byte(yaw_snap_next, pos[1:0]);
                end
            end
            CMD_STATUS: begin
                unique case (pos)
                    4'd0:    miso = flags_of(pitch_pwm_reg);
                    4'd1:    miso = pitch_pwm_reg.duty[7:0];
                    4'd2:    miso = flags_of(yaw_pwm_reg);
                    4'd3:    miso = yaw_pwm_reg.duty[7:0];
                    default: miso = 8'h00;
                endcase
            end
            default: begin
                // unknown command: silent frame
            end
        endcase
    end

    // reply carries the registers as they stand after this byte
    always_comb begin
        result.miso_byte    = miso;
        result.pitch        = pitch_pwm_next;
        result.yaw          = yaw_pwm_next;
        result.regs_updated = updated;
    end

    // frame control and pwm registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_idx_reg   <= '0;
            active_cmd_reg <= 8'h00;
            pitch_pwm_reg  <= '0;
            yaw_pwm_reg    <= '0;
        end else if (step) begin
            byte_idx_reg   <= byte_idx_next;
            active_cmd_reg <= active_cmd_next;
            pitch_pwm_reg  <= pitch_pwm_next;
            yaw_pwm_reg    <= yaw_pwm_next;
        end
    end

    // staging and snapshots, always written before they are read in a frame
    always_ff @(posedge aclk) begin
        if (step) begin
            staged_low_reg   <= staged_low_next;
            staged_pitch_reg <= staged_pitch_next;
            pitch_snap_reg   <= pitch_snap_next;
            yaw_snap_reg     <= yaw_snap_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/spwmcs_out_stage.sv =====
// ----------------------------------------------------------------------------
// spwmcs_out_stage
// Result register: holds one reply until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spwmcs_out_stage
    import spwmcs_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    load,
    input  wire result_t in_result,
    input  wire logic    out_ready,
    output logic         out_valid,
    output result_t      out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    // control flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= in_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

// ===== rtl/core/spi_pwm_encoder_command_slave_top.sv =====
// ----------------------------------------------------------------------------
// spi_pwm_encoder_command_slave_top
// Device side of a byte-wide SPI command protocol for two PWM channels and
// two encoder counters.
//
//   channel   direction  contents
//   s_axis    in         one SPI byte, frame start flag, encoder counts
//   m_axis    out        next MISO byte, pwm registers, write-done flag
//
// One byte per cycle sustained while m_axis_tready is high; a byte's reply
// passes the input register, the decode and then the result register to m_axis.
// A stall on m_axis holds the reply; the input register still takes one
// more byte, after which s_axis_tready drops until the reply is taken.
// Synchronous active-low reset clears frame state and both pwm registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "spi_pwm_encoder_command_slave_top_macros.svh"

module spi_pwm_encoder_command_slave_top
    import spwmcs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // mosi_byte[7:0], pitch_position[39:8], yaw_position[71:40]
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // frame_start
    input  wire logic                 s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // miso_byte[7:0], pitch_pwm_duty[19:8], pitch_pwm_en[20], pitch_motor_dir[21],
    // yaw_pwm_duty[33:22], yaw_pwm_en[34], yaw_motor_dir[35], regs_updated[36],
    // zero[39:37]
    output logic [M_TDATA_W-1:0]      m_axis_tdata
);

    item_t   in_item;
    item_t   held_item;
    logic    held_valid;
    logic    fire;
    result_t core_result;
    result_t out_result;

    // unpack the incoming transfer
    always_comb begin
        in_item.frame_start    = s_axis_tuser;
        in_item.mosi_byte      = s_axis_tdata[7:0];
        in_item.pitch_position = $signed(s_axis_tdata[39:8]);
        in_item.yaw_position   = $signed(s_axis_tdata[71:40]);
    end

    // a byte moves on when the result register is empty or draining
    assign fire = held_valid && (!m_axis_tvalid || m_axis_tready);

    spwmcs_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .take       (fire),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    spwmcs_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (fire),
        .item    (held_item),
        .result  (core_result)
    );

    spwmcs_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (fire),
        .in_result  (core_result),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_result (out_result)
    );

    // pack the outgoing transfer
    assign m_axis_tdata = {
        3'b000,
        out_result.regs_updated,
        out_result.yaw.dir,
        out_result.yaw.enable,
        out_result.yaw.duty,
        out_result.pitch.dir,
        out_result.pitch.enable,
        out_result.pitch.duty,
        out_result.miso_byte
    };

    // checks
    `SPWMCS_ASSERT_IMP(a_write_reply_silent, m_axis_tvalid && m_axis_tdata[36], m_axis_tdata[7:0] == 8'h00, "write completion with non-zero miso byte")
    `SPWMCS_ASSERT_NXT(a_fire_fills_output, fire, m_axis_tvalid, "decoded byte lost before result register")
    `SPWMCS_ASSERT_IMP(a_full_blocks_input, held_valid && m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while both stages are full")
    `SPWMCS_ASSERT_NXT(a_result_only_on_fire, m_axis_tvalid && !fire, $stable(m_axis_tdata), "result register changed without a decode step")

endmodule

`default_nettype wire

// ===== dv/tb_spi_pwm_encoder_command_slave_top.sv =====
// ----------------------------------------------------------------------------
// tb_spi_pwm_encoder_command_slave_top
// Self-checking bench for the SPI PWM/encoder command slave. SPI bytes are
// streamed in as s_axis transfers and every m_axis reply is checked field by
// field against a behavioural predictor of the frame decoder, the PWM
// registers and the position snapshots. A directed pass covers each command,
// the edge values and the odd frames, and then random frames follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_spi_pwm_encoder_command_slave_top;
    import spwmcs_pkg::*;

    localparam int unsigned RANDOM_BYTES = 700;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // mosi_byte[7:0], pitch_position[39:8], yaw_position[71:40]
    logic [S_TDATA_W-1:0] s_axis_tdata;
    // frame_start
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // miso_byte[7:0], pitch_pwm_duty[19:8], pitch_pwm_en[20], pitch_motor_dir[21],
    // yaw_pwm_duty[33:22], yaw_pwm_en[34], yaw_motor_dir[35], regs_updated[36],
    // zero[39:37]
    logic [M_TDATA_W-1:0] m_axis_tdata;

    // idling switches for each side
    logic send_gaps_on;
    logic recv_stalls_on;

    // predicted frame decoder and pwm state
    logic [IDX_W-1:0] frame_pos   = '0;
    logic [7:0]       cur_cmd     = '0;
    logic [7:0]       low_stage   = '0;
    pwm_reg_t         pitch_stage = '0;
    logic [31:0]      pitch_snap  = '0;
    logic [31:0]      yaw_snap    = '0;
    pwm_reg_t         pitch_reg   = '0;
    pwm_reg_t         yaw_reg     = '0;

    result_t     expected_replies[$];
    int unsigned bytes_sent;
    int unsigned mismatch_count;

    spi_pwm_encoder_command_slave_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 2 ns clock
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // hard stop in case the bench hangs
    initial begin
        #400000;
        $display("spi_pwm_encoder_command_slave_top verification failed");
        $finish;
    end

    // duty low byte and flags byte to a pwm register; flag bits 1:0 are dropped
    function automatic pwm_reg_t regs_from_bytes(input logic [7:0] lo, input logic [7:0] fl);
        pwm_reg_t r;
        r.enable = fl[7];
        r.dir    = fl[6];
        r.duty   = {fl[5:2], lo};
        return r;
    endfunction

    // flags byte as returned by the status command
    function automatic logic [7:0] status_flags(input pwm_reg_t r);
        return {r.enable, r.dir, r.duty[11:8], 2'b00};
    endfunction

    // advance the predicted decoder by one byte and form its reply
    task automatic predict_reply(input logic start, input logic [7:0] b,
                                 input logic [31:0] pp, input logic [31:0] yp,
                                 output result_t r);
        logic [IDX_W-1:0] pos;
        logic [31:0]      shifted;
        r       = '0;
        shifted = '0;
        if (start) begin
            cur_cmd   = b;
            pos       = '0;
            frame_pos = 4'd1;
            if (b == CMD_RD_PITCH || b == CMD_RD_YAW || b == CMD_RD_ALL) begin
                pitch_snap = pp;
                yaw_snap   = yp;
            end
        end else begin
            pos = frame_pos;
            if (frame_pos != IDX_MAX) frame_pos = frame_pos + 4'd1;
        end
        case (cur_cmd)
            CMD_WR_PITCH, CMD_WR_YAW: begin
                if (pos == 4'd1) begin
                    low_stage = b;
                end else if (pos == 4'd2) begin
                    if (cur_cmd == CMD_WR_PITCH) pitch_reg = regs_from_bytes(low_stage, b);
                    else yaw_reg = regs_from_bytes(low_stage, b);
                    r.regs_updated = 1'b1;
                end
            end
            CMD_WR_ALL: begin
                if (pos == 4'd1 || pos == 4'd3) begin
                    low_stage = b;
                end else if (pos == 4'd2) begin
                    pitch_stage = regs_from_bytes(low_stage, b);
                end else if (pos == 4'd4) begin
                    pitch_reg      = pitch_stage;
                    yaw_reg        = regs_from_bytes(low_stage, b);
                    r.regs_updated = 1'b1;
                end
            end
            CMD_RD_PITCH: begin
                if (pos <= 4'd3) shifted = pitch_snap >> (8 * (3 - pos[1:0]));
            end
            CMD_RD_YAW: begin
                if (pos <= 4'd3) shifted = yaw_snap >> (8 * (3 - pos[1:0]));
            end
            CMD_RD_ALL: begin
                if (pos <= 4'd3) shifted = pitch_snap >> (8 * (3 - pos[1:0]));
                else if (pos <= 4'd7) shifted = yaw_snap >> (8 * (3 - pos[1:0]));
            end
            CMD_STATUS: begin
                case (pos)
                    4'd0:    shifted = {24'd0, status_flags(pitch_reg)};
                    4'd1:    shifted = {24'd0, pitch_reg.duty[7:0]};
                    4'd2:    shifted = {24'd0, status_flags(yaw_reg)};
                    4'd3:    shifted = {24'd0, yaw_reg.duty[7:0]};
                    default: shifted = '0;
                endcase
            end
            default: ;
        endcase
        r.miso_byte = shifted[7:0];
        r.pitch     = pitch_reg;
        r.yaw       = yaw_reg;
    endtask

    task automatic report_mismatch(input string field, input logic [39:0] got,
                                   input logic [39:0] want);
        mismatch_count++;
        $display("%0t ns: %s got %h, expected %h", $time, field, got, want);
    endtask

    // one byte over s_axis; entered and left just after a falling edge
    task automatic send_byte(input logic start, input logic [7:0] b,
                             input logic [31:0] pp, input logic [31:0] yp);
        int unsigned gap;
        result_t     want;
        gap = send_gaps_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= start;
        s_axis_tdata  <= {yp, pp, b};
        do @(posedge aclk); while (!s_axis_tready);
        predict_reply(start, b, pp, yp, want);
        expected_replies.push_back(want);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // encoder count, leaning on the extremes now and then
    function automatic logic [31:0] rand_position();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // command byte followed by random data bytes
    task automatic send_frame(input logic [7:0] cmd, input int unsigned nbytes);
        for (int unsigned i = 0; i < nbytes; i++)
            send_byte(i == 0, (i == 0) ? cmd : 8'($urandom_range(0, 255)),
                      rand_position(), rand_position());
    endtask

    function automatic logic [7:0] pick_command();
        case ($urandom_range(0, 6))
            0:       return CMD_WR_PITCH;
            1:       return CMD_WR_YAW;
            2:       return CMD_WR_ALL;
            3:       return CMD_RD_PITCH;
            4:       return CMD_RD_YAW;
            5:       return CMD_RD_ALL;
            default: return CMD_STATUS;
        endcase
    endfunction

    // frame length per command, command byte included; reads get one byte past the reply
    function automatic int unsigned frame_bytes(input logic [7:0] cmd);
        case (cmd)
            CMD_WR_PITCH, CMD_WR_YAW: return 3;
            CMD_WR_ALL:               return 5;
            CMD_RD_ALL:               return 9;
            default:                  return 5;
        endcase
    endfunction

    // receiver: random stall ahead of each reply, then hold ready until taken
    initial begin : reply_sink
        int unsigned stall;
        m_axis_tready = 1'b0;
        @(negedge aclk);
        while (aresetn !== 1'b1) @(negedge aclk);
        forever begin
            stall = recv_stalls_on ? $urandom_range(0, 7) : 0;
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!(m_axis_tvalid && m_axis_tready));
            @(negedge aclk);
        end
    end

    // compare each reply transfer with the oldest prediction
    always @(posedge aclk) begin : reply_check
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_replies.size() == 0) begin
                report_mismatch("unexpected reply", m_axis_tdata, '0);
            end else begin
                want = expected_replies.pop_front();
                if (m_axis_tdata[7:0] !== want.miso_byte)
                    report_mismatch("miso_byte", 40'(m_axis_tdata[7:0]),
                                    40'(want.miso_byte));
                if (m_axis_tdata[19:8] !== want.pitch.duty)
                    report_mismatch("pitch_pwm_duty", 40'(m_axis_tdata[19:8]),
                                    40'(want.pitch.duty));
                if (m_axis_tdata[20] !== want.pitch.enable)
                    report_mismatch("pitch_pwm_en", 40'(m_axis_tdata[20]),
                                    40'(want.pitch.enable));
                if (m_axis_tdata[21] !== want.pitch.dir)
                    report_mismatch("pitch_motor_dir", 40'(m_axis_tdata[21]),
                                    40'(want.pitch.dir));
                if (m_axis_tdata[33:22] !== want.yaw.duty)
                    report_mismatch("yaw_pwm_duty", 40'(m_axis_tdata[33:22]),
                                    40'(want.yaw.duty));
                if (m_axis_tdata[34] !== want.yaw.enable)
                    report_mismatch("yaw_pwm_en", 40'(m_axis_tdata[34]),
                                    40'(want.yaw.enable));
                if (m_axis_tdata[35] !== want.yaw.dir)
                    report_mismatch("yaw_motor_dir", 40'(m_axis_tdata[35]),
                                    40'(want.yaw.dir));
                if (m_axis_tdata[36] !== want.regs_updated)
                    report_mismatch("regs_updated", 40'(m_axis_tdata[36]),
                                    40'(want.regs_updated));
                if (m_axis_tdata[39:37] !== 3'b000)
                    report_mismatch("padding", 40'(m_axis_tdata[39:37]), '0);
            end
        end
    end

    // data bytes with no frame yet: ignored, zero reply
    task automatic test_bytes_before_frame();
        send_byte(1'b0, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // full-write and yaw-write commands, full-scale and zero values, ignored flag bits
    task automatic test_pwm_writes();
        send_byte(1'b1, CMD_WR_ALL, rand_position(), rand_position());
        send_byte(1'b0, 8'hFF, rand_position(), rand_position());
        send_byte(1'b0, 8'hFF, rand_position(), rand_position());
        send_byte(1'b0, 8'h00, rand_position(), rand_position());
        send_byte(1'b0, 8'h00, rand_position(), rand_position());
        send_byte(1'b1, CMD_WR_YAW, rand_position(), rand_position());
        send_byte(1'b0, 8'hA5, rand_position(), rand_position());
        send_byte(1'b0, 8'h57, rand_position(), rand_position());
    endtask

    // write cut off by the next frame start must leave the registers alone
    task automatic test_aborted_write();
        send_byte(1'b1, CMD_WR_PITCH, rand_position(), rand_position());
        send_byte(1'b0, 8'h3C, rand_position(), rand_position());
    endtask

    // status readback of both channels
    task automatic test_status_readback();
        send_frame(CMD_STATUS, 4);
    endtask

    // snapshots at the extremes, counts moving during the frame, extra byte
    task automatic test_position_reads();
        send_byte(1'b1, CMD_RD_ALL, 32'h8000_0000, 32'h7FFF_FFFF);
        for (int unsigned i = 0; i < 8; i++)
            send_byte(1'b0, 8'($urandom_range(0, 255)), rand_position(), rand_position());
        send_byte(1'b1, CMD_RD_PITCH, 32'hFFFF_FFFF, 32'h0000_0000);
        send_byte(1'b0, 8'h00, rand_position(), rand_position());
        send_byte(1'b1, CMD_RD_YAW, 32'h0000_0000, 32'hFFFF_FFFF);
    endtask

    // unknown command answers zero for the whole frame
    task automatic test_unknown_command();
        send_byte(1'b1, 8'h00, rand_position(), rand_position());
        send_byte(1'b0, 8'hFF, rand_position(), rand_position());
    endtask

    // mostly well-formed frames, with truncated, unknown and overlong ones mixed in
    task automatic test_random_frames();
        int unsigned first;
        int unsigned kind;
        logic [7:0]  cmd;
        first = bytes_sent;
        while (bytes_sent - first < RANDOM_BYTES) begin
            if ($urandom_range(0, 15) == 0)
                {send_gaps_on, recv_stalls_on} = 2'($urandom_range(0, 3));
            kind = $urandom_range(0, 99);
            cmd  = pick_command();
            if (kind < 80) begin
                if ($urandom_range(0, 3) == 0)
                    send_frame(cmd, frame_bytes(cmd) + $urandom_range(1, 4));
                else
                    send_frame(cmd, frame_bytes(cmd));
            end else if (kind < 88) begin
                send_frame(cmd, $urandom_range(1, frame_bytes(cmd) - 1));
            end else if (kind < 96) begin
                send_frame(8'($urandom_range(0, 255)), $urandom_range(1, 6));
            end else begin
                send_frame(cmd, $urandom_range(16, 24));
            end
        end
    endtask

    // reset, tests in turn, drain, verdict
    initial begin
        aresetn        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        send_gaps_on   = 1'b1;
        recv_stalls_on = 1'b1;
        bytes_sent     = 0;
        mismatch_count = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_bytes_before_frame();
        test_pwm_writes();
        test_aborted_write();
        test_status_readback();
        test_position_reads();
        test_unknown_command();
        test_random_frames();

        s_axis_tvalid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("spi_pwm_encoder_command_slave_top verification clean");
        else
            $display("spi_pwm_encoder_command_slave_top verification failed");
        $finish;
    end

endmodule
